@@ hdl/esc_pkg.sv @@
`default_nettype none
package esc_pkg;

    // Register indexes on the configuration port (byte address is 8 * index).
    localparam logic [2:0] REG_TEMP_TRIM  = 3'd0;
    localparam logic [2:0] REG_PRES_LOW   = 3'd1;
    localparam logic [2:0] REG_PRES_HIGH  = 3'd2;
    localparam logic [2:0] REG_PRES_LAST  = 3'd3;
    localparam logic [2:0] REG_HUM_TRIM   = 3'd4;

    // Datapath step codes, at most one multiply per step.
    localparam logic [4:0] STEP_T_A      = 5'd0;
    localparam logic [4:0] STEP_T_SQ     = 5'd1;
    localparam logic [4:0] STEP_T_FINE   = 5'd2;
    localparam logic [4:0] STEP_T_OUT    = 5'd3;
    localparam logic [4:0] STEP_P_Q2     = 5'd4;
    localparam logic [4:0] STEP_P_B6     = 5'd5;
    localparam logic [4:0] STEP_P_B5     = 5'd6;
    localparam logic [4:0] STEP_P_A3     = 5'd7;
    localparam logic [4:0] STEP_P_A2     = 5'd8;
    localparam logic [4:0] STEP_P_DIV    = 5'd9;
    localparam logic [4:0] STEP_P_NUM    = 5'd10;
    localparam logic [4:0] STEP_P_S1     = 5'd11;
    localparam logic [4:0] STEP_P_A9     = 5'd12;
    localparam logic [4:0] STEP_P_B8     = 5'd13;
    localparam logic [4:0] STEP_P_OUT    = 5'd14;
    localparam logic [4:0] STEP_H_X      = 5'd15;
    localparam logic [4:0] STEP_H_Y6     = 5'd16;
    localparam logic [4:0] STEP_H_Z3     = 5'd17;
    localparam logic [4:0] STEP_H_YZ     = 5'd18;
    localparam logic [4:0] STEP_H_Y2     = 5'd19;
    localparam logic [4:0] STEP_H_V      = 5'd20;
    localparam logic [4:0] STEP_H_D      = 5'd21;
    localparam logic [4:0] STEP_H_OUT    = 5'd22;

    localparam int DIV_BITS = 32;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] pres_low;
        logic [63:0] pres_high;
        logic [15:0] pres_last;
        logic [63:0] hum;
    } t_trim;

    typedef struct packed {
        logic       exec;
        logic [4:0] step;
        logic       load_in;
        logic       div_run;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic div_zero;
    } t_status;

endpackage
`default_nettype wire

@@ hdl/environmental_sensor_compensation.sv @@
`default_nettype none
// Channel     | Direction | Payload
// s_axis      | in        | tdata: raw_temperature, raw_pressure, raw_humidity
// m_axis      | out       | tdata: temperature_centi, pressure_pa, humidity_q10;
//             |           | tuser: pressure_fresh
// apb         | in/out    | five trimming registers at byte address 8 * index
//
// An item runs from input transfer to a loaded result through 23 datapath
// steps on the shared 32x32 multiplier, the restoring divider iterations (one
// quotient bit each) and a load of the output register. A zero pressure
// divisor skips the divider and the pressure tail.
// The next input is taken in the cycle after the result is loaded.
// Reset is synchronous and active low; it clears control state, trims and the
// held pressure. The next item is taken while a result waits on the output;
// the block stalls before loading a new result until the old one is taken.
module environmental_sensor_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [19:0] raw_temperature, [39:20] raw_pressure, [55:40] raw_humidity
    input  wire logic [55:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [15:0] temperature_centi, [33:16] pressure_pa, [50:34] humidity_q10, rest zero
    output logic      [55:0] o_m_axis_tdata,
    // [0] pressure_fresh
    output logic      [0:0]  o_m_axis_tuser,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [5:0]  i_paddr,
    input  wire logic [63:0] i_pwdata,
    output logic      [63:0] o_prdata,
    output logic             o_pready
);
    import esc_pkg::*;

    t_trim              trim;
    t_cmd               cmd;
    t_status            status;
    logic signed [15:0] temp;
    logic        [17:0] pres;
    logic               fresh;
    logic        [16:0] hum;

    esc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_trim    (trim)
    );

    esc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    esc_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_trim              (trim),
        .i_raw_temperature   (i_s_axis_tdata[19:0]),
        .i_raw_pressure      (i_s_axis_tdata[39:20]),
        .i_raw_humidity      (i_s_axis_tdata[55:40]),
        .o_status            (status),
        .o_temperature_centi (temp),
        .o_pressure_pa       (pres),
        .o_pressure_fresh    (fresh),
        .o_humidity_q10      (hum)
    );

    assign o_m_axis_tdata = {5'd0, hum, pres, temp};
    assign o_m_axis_tuser = fresh;
    assign o_pready       = 1'b1;

endmodule
`default_nettype wire

@@ hdl/esc_regs.sv @@
`default_nettype none
module esc_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_psel,
    input  wire logic          i_penable,
    input  wire logic          i_pwrite,
    input  wire logic [5:0]    i_paddr,
    input  wire logic [63:0]   i_pwdata,
    output logic      [63:0]   o_prdata,
    output esc_pkg::t_trim     o_trim
);
    import esc_pkg::*;

    t_trim r_trim;
    logic  wr_en;

    assign wr_en = i_psel & i_penable & i_pwrite;

    // Register writes, decoded on the register index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim <= '0;
        end else if (wr_en) begin
            case (i_paddr[5:3])
                REG_TEMP_TRIM: r_trim.temp      <= i_pwdata[47:0];
                REG_PRES_LOW:  r_trim.pres_low  <= i_pwdata;
                REG_PRES_HIGH: r_trim.pres_high <= i_pwdata;
                REG_PRES_LAST: r_trim.pres_last <= i_pwdata[15:0];
                REG_HUM_TRIM:  r_trim.hum       <= i_pwdata;
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (i_paddr[5:3])
            REG_TEMP_TRIM: o_prdata = {16'd0, r_trim.temp};
            REG_PRES_LOW:  o_prdata = r_trim.pres_low;
            REG_PRES_HIGH: o_prdata = r_trim.pres_high;
            REG_PRES_LAST: o_prdata = {48'd0, r_trim.pres_last};
            REG_HUM_TRIM:  o_prdata = r_trim.hum;
            default:       o_prdata = '0;
        endcase
    end

    assign o_trim = r_trim;

endmodule
`default_nettype wire

@@ hdl/esc_dp.sv @@
`default_nettype none
module esc_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire esc_pkg::t_cmd  i_cmd,
    input  wire esc_pkg::t_trim i_trim,
    input  wire logic [19:0]   i_raw_temperature,
    input  wire logic [19:0]   i_raw_pressure,
    input  wire logic [15:0]   i_raw_humidity,
    output esc_pkg::t_status   o_status,
    output logic signed [15:0] o_temperature_centi,
    output logic [17:0]        o_pressure_pa,
    output logic               o_pressure_fresh,
    output logic [16:0]        o_humidity_q10
);
    import esc_pkg::*;

    // Captured raw readings.
    logic [19:0] r_adc_t, r_adc_p;
    logic [15:0] r_adc_h;

    // Working registers; the 32-bit ones are two's complement but for r_s1, r_quo and r_rem.
    logic signed [31:0] r_ta, r_tb, r_fine, r_pa, r_q2, r_pb, r_px, r_py, r_div;
    logic signed [31:0] r_hv, r_hx, r_hy, r_hz;
    logic        [31:0] r_s1, r_quo, r_rem;
    logic               r_big;
    logic signed [15:0] r_temp;
    logic        [17:0] r_held;
    logic               r_fresh;
    logic        [16:0] r_hum;

    // Output registers.
    logic signed [15:0] r_o_temp;
    logic        [17:0] r_o_pres;
    logic               r_o_fresh;
    logic        [16:0] r_o_hum;

    // Trimming coefficients.
    logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = $signed({16'd0, i_trim.temp[15:0]});
    assign t2 = 32'(signed'(i_trim.temp[31:16]));
    assign t3 = 32'(signed'(i_trim.temp[47:32]));
    assign p1 = $signed({16'd0, i_trim.pres_low[15:0]});
    assign p2 = 32'(signed'(i_trim.pres_low[31:16]));
    assign p3 = 32'(signed'(i_trim.pres_low[47:32]));
    assign p4 = 32'(signed'(i_trim.pres_low[63:48]));
    assign p5 = 32'(signed'(i_trim.pres_high[15:0]));
    assign p6 = 32'(signed'(i_trim.pres_high[31:16]));
    assign p7 = 32'(signed'(i_trim.pres_high[47:32]));
    assign p8 = 32'(signed'(i_trim.pres_high[63:48]));
    assign p9 = 32'(signed'(i_trim.pres_last));
    assign h1 = $signed({24'd0, i_trim.hum[7:0]});
    assign h2 = 32'(signed'(i_trim.hum[23:8]));
    assign h3 = $signed({24'd0, i_trim.hum[31:24]});
    assign h4 = 32'(signed'(i_trim.hum[43:32]));
    assign h5 = 32'(signed'(i_trim.hum[55:44]));
    assign h6 = 32'(signed'(i_trim.hum[63:56]));

    // Values derived from registers without a multiply, and the multiplier and divider nets.
    logic signed [31:0] st, d1, d2, pa, pnum, hv, hx1, pu;
    logic signed [31:0] mul_a, mul_b, pl, tt, pr, hsum;
    logic signed [63:0] prod;
    logic        [31:0] dividend, rem_next;
    logic        [32:0] rem_sh;
    logic               rem_ge;

    assign st   = $signed({12'd0, r_adc_t});
    assign d1   = (st >>> 3) - (t1 <<< 1);
    assign d2   = (st >>> 4) - t1;
    assign pa   = (r_fine >>> 1) - 32'sd64000;
    assign pnum = (32'sd1048576 - $signed({12'd0, r_adc_p})) - (r_pb >>> 12);
    assign hv   = r_fine - 32'sd76800;
    assign hx1  = $signed({2'd0, r_adc_h, 14'd0}) - (h4 <<< 20);
    assign pu   = r_big ? $signed({r_quo[30:0], 1'b0}) : $signed(r_quo);

    // Shared multiplier operand select.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.step)
            STEP_T_A:    begin mul_a = d1;                     mul_b = t2;           end
            STEP_T_SQ:   begin mul_a = d2;                     mul_b = d2;           end
            STEP_T_FINE: begin mul_a = r_tb;                   mul_b = t3;           end
            STEP_T_OUT:  begin mul_a = r_fine;                 mul_b = 32'sd5;       end
            STEP_P_Q2:   begin mul_a = pa >>> 2;               mul_b = pa >>> 2;     end
            STEP_P_B6:   begin mul_a = r_q2 >>> 11;            mul_b = p6;           end
            STEP_P_B5:   begin mul_a = r_pa;                   mul_b = p5;           end
            STEP_P_A3:   begin mul_a = p3;                     mul_b = r_q2 >>> 13;  end
            STEP_P_A2:   begin mul_a = p2;                     mul_b = r_pa;         end
            STEP_P_DIV:  begin mul_a = 32'sd32768 + r_px;      mul_b = p1;           end
            STEP_P_NUM:  begin mul_a = pnum;                   mul_b = 32'sd3125;    end
            STEP_P_S1:   begin mul_a = $signed({3'd0, pu[31:3]});
                               mul_b = $signed({3'd0, pu[31:3]});                    end
            STEP_P_A9:   begin mul_a = p9;                     mul_b = $signed(r_s1); end
            STEP_P_B8:   begin mul_a = $signed({2'd0, pu[31:2]}); mul_b = p8;        end
            STEP_H_X:    begin mul_a = h5;                     mul_b = hv;           end
            STEP_H_Y6:   begin mul_a = r_hv;                   mul_b = h6;           end
            STEP_H_Z3:   begin mul_a = r_hv;                   mul_b = h3;           end
            STEP_H_YZ:   begin mul_a = r_hy;                   mul_b = r_hz;         end
            STEP_H_Y2:   begin mul_a = r_hy;                   mul_b = h2;           end
            STEP_H_V:    begin mul_a = r_hx;                   mul_b = r_hy;         end
            STEP_H_D:    begin mul_a = r_hv >>> 15;            mul_b = r_hv >>> 15;  end
            STEP_H_OUT:  begin mul_a = r_hz;                   mul_b = h1;           end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;
    assign pl   = prod[31:0];
    assign tt   = (pl + 32'sd128) >>> 8;
    assign pr   = pu + ((r_px + r_py + p7) >>> 4);
    assign hsum = r_hv - (pl >>> 4);

    // Numerator for the divider; a large product is divided as is and doubled later.
    assign dividend = pl[31] ? pl : {pl[30:0], 1'b0};

    // One restoring division step.
    assign rem_sh   = {r_rem, r_quo[31]};
    assign rem_ge   = rem_sh >= {1'b0, r_div};
    assign rem_next = rem_ge ? 32'(rem_sh - {1'b0, r_div}) : rem_sh[31:0];

    // Capture of raw readings.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_adc_t <= i_raw_temperature;
            r_adc_p <= i_raw_pressure;
            r_adc_h <= i_raw_humidity;
        end
    end

    // Held pressure survives between items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.exec && i_cmd.step == STEP_P_OUT) begin
            if (pr[31])
                r_held <= '0;
            else if (pr > 32'sd262143)
                r_held <= '1;
            else
                r_held <= pr[17:0];
        end
    end

    // Step results and divider iterations.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_run) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[30:0], rem_ge};
        end else if (i_cmd.exec) begin
            case (i_cmd.step)
                STEP_T_A: begin
                    r_ta    <= pl >>> 11;
                    r_fresh <= 1'b0;
                end
                STEP_T_SQ:   r_tb   <= pl >>> 12;
                STEP_T_FINE: r_fine <= r_ta + (pl >>> 14);
                STEP_T_OUT: begin
                    if (tt < -32'sd32768)
                        r_temp <= 16'sh8000;
                    else if (tt > 32'sd32767)
                        r_temp <= 16'sh7fff;
                    else
                        r_temp <= tt[15:0];
                end
                STEP_P_Q2: begin
                    r_pa <= pa;
                    r_q2 <= pl;
                end
                STEP_P_B6:  r_pb  <= pl;
                STEP_P_B5:  r_pb  <= ((r_pb + (pl <<< 1)) >>> 2) + (p4 <<< 16);
                STEP_P_A3:  r_px  <= pl >>> 3;
                STEP_P_A2:  r_px  <= (r_px + (pl >>> 1)) >>> 18;
                STEP_P_DIV: r_div <= pl >>> 15;
                STEP_P_NUM: begin
                    r_quo <= dividend;
                    r_rem <= '0;
                    r_big <= pl[31];
                end
                STEP_P_S1:  r_s1    <= {13'd0, pl[31:13]};
                STEP_P_A9:  r_px    <= pl >>> 12;
                STEP_P_B8:  r_py    <= pl >>> 13;
                STEP_P_OUT: r_fresh <= 1'b1;
                STEP_H_X: begin
                    r_hv <= hv;
                    r_hx <= (hx1 - pl + 32'sd16384) >>> 15;
                end
                STEP_H_Y6:  r_hy <= pl >>> 10;
                STEP_H_Z3:  r_hz <= (pl >>> 11) + 32'sd32768;
                STEP_H_YZ:  r_hy <= (pl >>> 10) + 32'sd2097152;
                STEP_H_Y2:  r_hy <= (pl + 32'sd8192) >>> 14;
                STEP_H_V:   r_hv <= pl;
                STEP_H_D:   r_hz <= pl >>> 7;
                STEP_H_OUT: begin
                    if (hsum[31])
                        r_hum <= '0;
                    else if (hsum > 32'sd419430400)
                        r_hum <= 17'd102400;
                    else
                        r_hum <= hsum[28:12];
                end
                default: ;
            endcase
        end
    end

    // Output register, loaded when the result is complete.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_temp  <= r_temp;
            r_o_pres  <= r_held;
            r_o_fresh <= r_fresh;
            r_o_hum   <= r_hum;
        end
    end

    assign o_status.div_zero   = (r_div == '0);
    assign o_temperature_centi = r_o_temp;
    assign o_pressure_pa       = r_o_pres;
    assign o_pressure_fresh    = r_o_fresh;
    assign o_humidity_q10      = r_o_hum;

endmodule
`default_nettype wire

@@ hdl/esc_ctrl.sv @@
`default_nettype none
module esc_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    input  wire esc_pkg::t_status i_status,
    output esc_pkg::t_cmd    o_cmd
);
    import esc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RUN    = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       in_xfer, out_free;

    assign in_xfer  = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer through the datapath steps.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        if (r_out_valid && i_out_ready)
            n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.load_in = 1'b1;
                    n_step        = STEP_T_A;
                    n_state       = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.exec = 1'b1;
                if (r_step == STEP_P_NUM) begin
                    // A zero divisor skips the pressure tail and keeps the held value.
                    if (i_status.div_zero) begin
                        n_step = STEP_H_X;
                    end else begin
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end else if (r_step == STEP_H_OUT) begin
                    n_state = S_FINISH;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            S_DIV: begin
                o_cmd.div_run = 1'b1;
                n_cnt         = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_BITS - 1)) begin
                    n_step  = STEP_P_S1;
                    n_state = S_RUN;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ hdl/esc_sva.sv @@
`default_nettype none
module esc_sva (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [55:0] o_m_axis_tdata,
    input wire logic [0:0]  o_m_axis_tuser,
    input wire logic        o_pready
);
    // A stalled result keeps its valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // Humidity never leaves its clamped range.
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[50:34] <= 17'd102400)
        else $error("humidity out of range");

    // One item at a time: no input is taken right after a transfer.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while busy");

    // The register port never waits.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_pready)
        else $error("pready low");

endmodule

bind environmental_sensor_compensation esc_sva u_esc_sva (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_pready        (o_pready)
);
`default_nettype wire
